FILE: hw/rtl/xfrr_pkg.sv
// shared types and constants of the xor framed response receiver
package xfrr_pkg;

    localparam logic [1:0] ACT_ARM  = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_SCAN     = 3'd1;
    localparam logic [2:0] PH_OPCODE   = 3'd2;
    localparam logic [2:0] PH_STATUS   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_CHECKSUM = 3'd5;

    localparam logic [2:0] OUT_OK       = 3'd0;
    localparam logic [2:0] OUT_TIMEOUT  = 3'd1;
    localparam logic [2:0] OUT_OPCODE   = 3'd2;
    localparam logic [2:0] OUT_STATUS   = 3'd3;
    localparam logic [2:0] OUT_CHECKSUM = 3'd4;

    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] REG_STATUS_OK    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT      = 2'd3;

    localparam logic [7:0]  MAGIC_FIRST_RST  = 8'd109;
    localparam logic [7:0]  MAGIC_SECOND_RST = 8'd115;
    localparam logic [7:0]  STATUS_OK_RST    = 8'd0;
    localparam logic [15:0] TIMEOUT_RST      = 16'd1000;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  expected_op;
        logic [15:0] body_len;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        is_final;
        logic [7:0]  data_byte;
        logic [2:0]  outcome;
        logic [7:0]  status_seen;
    } result_t;

endpackage

FILE: hw/rtl/xfrr_in_stage.sv
// input register stage holding one accepted transaction
module xfrr_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  xfrr_pkg::item_t       in_item,
    input  logic                  advance,
    output logic                  item_valid,
    output xfrr_pkg::item_t       item
);

    logic            valid_reg;
    logic            valid_next;
    xfrr_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/xfrr_core.sv
// receive state machine, configuration registers and result generation
module xfrr_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  step,
    input  xfrr_pkg::item_t       item,
    output logic                  res_valid,
    output xfrr_pkg::result_t     res
);

    logic [7:0]  magic_first_reg;
    logic [7:0]  magic_second_reg;
    logic [7:0]  status_ok_reg;
    logic [15:0] timeout_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [7:0]  run_xor_reg, run_xor_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  wanted_op_reg, wanted_op_next;
    logic [7:0]  status_byte_reg, status_byte_next;
    logic        status_good_reg, status_good_next;

    logic [15:0] tick_inc;
    logic [15:0] bytes_dec;
    logic [7:0]  b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg  <= xfrr_pkg::MAGIC_FIRST_RST;
            magic_second_reg <= xfrr_pkg::MAGIC_SECOND_RST;
            status_ok_reg    <= xfrr_pkg::STATUS_OK_RST;
            timeout_reg      <= xfrr_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                xfrr_pkg::REG_MAGIC_FIRST:  magic_first_reg  <= cfg_data[7:0];
                xfrr_pkg::REG_MAGIC_SECOND: magic_second_reg <= cfg_data[7:0];
                xfrr_pkg::REG_STATUS_OK:    status_ok_reg    <= cfg_data[7:0];
                xfrr_pkg::REG_TIMEOUT:      timeout_reg      <= cfg_data;
                default:                    magic_first_reg  <= magic_first_reg;
            endcase
        end
    end

    assign b         = item.rx_byte;
    assign tick_inc  = (tick_count_reg == 16'hFFFF) ? tick_count_reg : tick_count_reg + 16'd1;
    assign bytes_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        prev_byte_next   = prev_byte_reg;
        run_xor_next     = run_xor_reg;
        bytes_left_next  = bytes_left_reg;
        tick_count_next  = tick_count_reg;
        wanted_op_next   = wanted_op_reg;
        status_byte_next = status_byte_reg;
        status_good_next = status_good_reg;
        res_valid        = 1'b0;
        res.is_final     = 1'b1;
        res.data_byte    = 8'd0;
        res.outcome      = xfrr_pkg::OUT_OK;

        if (item.action == xfrr_pkg::ACT_ARM)
        begin
            phase_next       = xfrr_pkg::PH_SCAN;
            wanted_op_next   = item.expected_op;
            bytes_left_next  = item.body_len;
            prev_byte_next   = 8'd0;
            run_xor_next     = 8'd0;
            tick_count_next  = 16'd0;
            status_byte_next = 8'd0;
            status_good_next = 1'b0;
        end
        else if (phase_reg != xfrr_pkg::PH_IDLE && item.action == xfrr_pkg::ACT_TICK)
        begin
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_reg)
            begin
                phase_next  = xfrr_pkg::PH_IDLE;
                res_valid   = 1'b1;
                res.outcome = xfrr_pkg::OUT_TIMEOUT;
            end
        end
        else if (phase_reg != xfrr_pkg::PH_IDLE && item.action == xfrr_pkg::ACT_BYTE)
        begin
            unique case (phase_reg)
                xfrr_pkg::PH_SCAN:
                begin
                    if (prev_byte_reg == magic_first_reg && b == magic_second_reg)
                    begin
                        run_xor_next    = magic_first_reg ^ magic_second_reg;
                        tick_count_next = 16'd0;
                        phase_next      = xfrr_pkg::PH_OPCODE;
                    end
                    else
                    begin
                        prev_byte_next = b;
                    end
                end
                xfrr_pkg::PH_OPCODE:
                begin
                    tick_count_next = 16'd0;
                    wanted_op_next  = wanted_op_reg ^ b;
                    run_xor_next    = run_xor_reg ^ b;
                    phase_next      = xfrr_pkg::PH_STATUS;
                end
                xfrr_pkg::PH_STATUS:
                begin
                    tick_count_next  = 16'd0;
                    status_byte_next = b;
                    run_xor_next     = run_xor_reg ^ b;
                    if (wanted_op_reg != 8'd0)
                    begin
                        phase_next  = xfrr_pkg::PH_IDLE;
                        res_valid   = 1'b1;
                        res.outcome = xfrr_pkg::OUT_OPCODE;
                    end
                    else
                    begin
                        status_good_next = (b == status_ok_reg);
                        phase_next = ((b == status_ok_reg) && bytes_left_reg != 16'd0)
                                     ? xfrr_pkg::PH_PAYLOAD : xfrr_pkg::PH_CHECKSUM;
                    end
                end
                xfrr_pkg::PH_PAYLOAD:
                begin
                    tick_count_next = 16'd0;
                    run_xor_next    = run_xor_reg ^ b;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        phase_next = xfrr_pkg::PH_CHECKSUM;
                    end
                    res_valid     = 1'b1;
                    res.is_final  = 1'b0;
                    res.data_byte = b;
                end
                xfrr_pkg::PH_CHECKSUM:
                begin
                    tick_count_next = 16'd0;
                    phase_next      = xfrr_pkg::PH_IDLE;
                    res_valid       = 1'b1;
                    if (b != run_xor_reg)
                    begin
                        res.outcome = xfrr_pkg::OUT_CHECKSUM;
                    end
                    else
                    begin
                        res.outcome = status_good_reg ? xfrr_pkg::OUT_OK
                                                      : xfrr_pkg::OUT_STATUS;
                    end
                end
                default:
                begin
                    phase_next = xfrr_pkg::PH_IDLE;
                end
            endcase
        end
        res.status_seen = status_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= xfrr_pkg::PH_IDLE;
            prev_byte_reg   <= 8'd0;
            run_xor_reg     <= 8'd0;
            bytes_left_reg  <= 16'd0;
            tick_count_reg  <= 16'd0;
            wanted_op_reg   <= 8'd0;
            status_byte_reg <= 8'd0;
            status_good_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            prev_byte_reg   <= prev_byte_next;
            run_xor_reg     <= run_xor_next;
            bytes_left_reg  <= bytes_left_next;
            tick_count_reg  <= tick_count_next;
            wanted_op_reg   <= wanted_op_next;
            status_byte_reg <= status_byte_next;
            status_good_reg <= status_good_next;
        end
    end

endmodule

FILE: hw/rtl/xfrr_out_stage.sv
// result register feeding the output stream
module xfrr_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  res_valid,
    input  xfrr_pkg::result_t     res,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output xfrr_pkg::result_t     out_res
);

    logic              valid_reg;
    logic              valid_next;
    xfrr_pkg::result_t res_reg;

    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: hw/rtl/xor_framed_response_receiver_top.sv
// top level of the xor framed response receiver
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser action, s_tdata op/len/byte
//  m_       out  m_tvalid/m_tready  m_tuser is_final, m_tdata byte/outcome/status
//  cfg_     in   cfg_we             cfg_index, cfg_data
//
// one transaction per cycle while m_tready does not stall; a result is offered
// on m_tvalid from the result register, loaded from the input register
// all control state clears on rst_n; configuration returns to its defaults
// a stall on m_tready holds the result register and backs up into the input
// register before s_tready drops
module xor_framed_response_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // expected_op, body_len, rx_byte
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte, outcome, status_seen, zero fill
    output logic        m_tuser,   // is_final
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    xfrr_pkg::item_t   in_item;
    xfrr_pkg::item_t   item;
    xfrr_pkg::result_t res;
    xfrr_pkg::result_t out_res;
    logic              item_valid;
    logic              room;
    logic              advance;
    logic              res_valid;

    assign in_item.action      = s_tuser;
    assign in_item.expected_op = s_tdata[7:0];
    assign in_item.body_len    = s_tdata[23:8];
    assign in_item.rx_byte     = s_tdata[31:24];

    assign advance = item_valid && room;

    xfrr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    xfrr_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (advance),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res)
    );

    xfrr_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .res_valid  (res_valid),
        .res        (res),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tuser = out_res.is_final;
    assign m_tdata = {5'd0, out_res.status_seen, out_res.outcome, out_res.data_byte};

endmodule
